>>> hdl/assert_macros.svh
// assert_macros.svh: assertion macros used by the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle
`define PGMB_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pgmb assertion failed");

// trigger implies consequence in the next cycle
`define PGMB_ASSERT_NEXT(name, clk, rst, trig, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("pgmb assertion failed");

`endif

>>> hdl/pgmb_pkg.sv
// pgmb_pkg: constants, codes and sequencer states of the height-grid binner.
// No dependencies.
`default_nettype none

package pgmb_pkg;

   localparam int MAX_COLS_DEF   = 64;
   localparam int MAX_ROWS_DEF   = 64;
   localparam int COUNT_BITS_DEF = 16;

   localparam int COORD_W = 32;
   localparam int Z_W     = 24;
   localparam int CS_W    = 24;
   localparam int GRID_W  = 7;
   localparam int IDX_W   = 6;
   localparam int HIT_W   = 16;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_SAT     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SIZE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_MODE = 3'd5;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PREP,
      ST_XSTART,
      ST_DIVX,
      ST_DIVY,
      ST_RANGE,
      ST_FETCH,
      ST_APPLY,
      ST_DIVM,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

>>> hdl/pgmb_ram.sv
// pgmb_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none

module pgmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

>>> hdl/pgmb_div.sv
// pgmb_div: shared restoring divider, one quotient bit per cycle.
// Unsigned dividend of DW bits over a 24-bit divisor; no package use.
`default_nettype none

module pgmb_div #(
   parameter int DW = 40
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [23:0]   divisor,
   output logic               done,
   output logic      [DW-1:0] quotient
);

   localparam int CNT_W = $clog2(DW + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [23:0]       rem_ff;
   logic [23:0]       dsr_ff;
   logic [DW-1:0]     quo_ff;
   logic [24:0]       shifted;
   logic [25:0]       diff;
   logic              qbit;

   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dsr_ff};
   assign qbit    = ~diff[25];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end else if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DW);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         quo_ff <= {quo_ff[DW-2:0], qbit};
         rem_ff <= qbit ? diff[23:0] : shifted[23:0];
      end else if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> hdl/point_grid_mean_binning_top.sv
// Height-grid binner: an add offsets the point by the origin, divides x, then y, by the cell size
// on the shared divider, range-checks the cell, reads it and writes it back; a read checks the
// range, reads the cell and divides its sum by its count unless that is zero; a clear zeroes the
// store. Rejected points finish sooner. One word at a time: the next is taken the cycle after the
// result leaves. The shared divider yields one quotient bit per cycle. Synchronous reset loads
// register defaults, then zeroes the store before the first word; CSR writes are taken throughout.
`default_nettype none

module point_grid_mean_binning_top #(
   parameter int MAX_COLS   = pgmb_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS   = pgmb_pkg::MAX_ROWS_DEF,
   parameter int COUNT_BITS = pgmb_pkg::COUNT_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [31:0] req_point_x,
   input  wire logic [31:0] req_point_y,
   input  wire logic [23:0] req_point_z,
   input  wire logic [5:0]  req_read_row,
   input  wire logic [5:0]  req_read_col,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [1:0]  rsp_status,
   output logic      [5:0]  rsp_cell_row,
   output logic      [5:0]  rsp_cell_col,
   output logic      [23:0] rsp_mean_height,
   output logic      [15:0] rsp_hit_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int SUM_W   = pgmb_pkg::Z_W + COUNT_BITS;
   localparam int ENTRY_W = SUM_W + COUNT_BITS;
   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int DIV_W   = (SUM_W > 32) ? SUM_W : 32;

   pgmb_pkg::state_type state_ff, state_in;

   logic signed [31:0] origin_x_ff, origin_y_ff;
   logic [23:0]        cell_size_ff;
   logic [6:0]         grid_cols_ff, grid_rows_ff;
   logic               write_mode_ff;

   logic [1:0]         cmd_ff;
   logic [31:0]        px_ff, py_ff;
   logic [23:0]        pz_ff;
   logic [32:0]        dx_ff, dy_ff;
   logic [DIV_W-1:0]   col_q_ff, row_q_ff;
   logic               neg_ff;
   logic               clr_rsp_ff;
   logic [ADDR_W-1:0]  clr_addr_ff;

   logic [1:0]         status_ff;
   logic [5:0]         row_out_ff, col_out_ff;
   logic [23:0]        mean_ff;
   logic [15:0]        hit_ff;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr, ram_raddr, cell_addr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

   logic               div_start, div_done;
   logic [DIV_W-1:0]   div_dividend, div_quot;
   logic [23:0]        div_divisor;

   logic               req_take, clr_last, coord_neg, out_rng;
   logic [DIV_W-1:0]   cols_eff, rows_eff;
   logic [SUM_W-1:0]   rd_sum, sum_plus, z_ext, sum_mag;
   logic [COUNT_BITS-1:0] rd_cnt, cnt_plus;
   logic [23:0]        quot24;

   assign req_take  = req_valid && !req_stall;
   assign clr_last  = clr_addr_ff == ADDR_W'(DEPTH - 1);
   assign coord_neg = dx_ff[32] || dy_ff[32];
   assign cols_eff  = (DIV_W'(grid_cols_ff) > DIV_W'(MAX_COLS)) ?
                      DIV_W'(MAX_COLS) : DIV_W'(grid_cols_ff);
   assign rows_eff  = (DIV_W'(grid_rows_ff) > DIV_W'(MAX_ROWS)) ?
                      DIV_W'(MAX_ROWS) : DIV_W'(grid_rows_ff);
   assign out_rng   = (col_q_ff >= cols_eff) || (row_q_ff >= rows_eff);
   assign cell_addr = ADDR_W'(ADDR_W'(row_q_ff[RW-1:0]) * ADDR_W'(MAX_COLS)) +
                      ADDR_W'(col_q_ff[CW-1:0]);

   assign rd_sum   = ram_rdata[ENTRY_W-1:COUNT_BITS];
   assign rd_cnt   = ram_rdata[COUNT_BITS-1:0];
   assign z_ext    = {{(SUM_W - pgmb_pkg::Z_W){pz_ff[23]}}, pz_ff};
   assign sum_plus = rd_sum + z_ext;
   assign cnt_plus = rd_cnt + COUNT_BITS'(1);
   assign sum_mag  = rd_sum[SUM_W-1] ? (~rd_sum + SUM_W'(1)) : rd_sum;
   assign quot24   = div_quot[23:0];

   function automatic logic [15:0] sat_hit(input logic [COUNT_BITS-1:0] c);
      logic [24:0] w;
      w = 25'(c);
      return (w > 25'd65535) ? 16'hFFFF : w[15:0];
   endfunction

   pgmb_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH), .AW(ADDR_W)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pgmb_div #(.DW(DIV_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         cell_size_ff  <= 24'd256;
         grid_cols_ff  <= 7'd64;
         grid_rows_ff  <= 7'd64;
         write_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pgmb_pkg::CSR_ORIGIN_X:   origin_x_ff   <= csr_wdata;
            pgmb_pkg::CSR_ORIGIN_Y:   origin_y_ff   <= csr_wdata;
            pgmb_pkg::CSR_CELL_SIZE:  cell_size_ff  <= csr_wdata[23:0];
            pgmb_pkg::CSR_GRID_COLS:  grid_cols_ff  <= csr_wdata[6:0];
            pgmb_pkg::CSR_GRID_ROWS:  grid_rows_ff  <= csr_wdata[6:0];
            pgmb_pkg::CSR_WRITE_MODE: write_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pgmb_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = clr_rsp_ff ? pgmb_pkg::ST_RESP : pgmb_pkg::ST_IDLE;
            end
         end
         pgmb_pkg::ST_IDLE: begin
            if (req_take) begin
               case (req_command)
                  pgmb_pkg::CMD_ADD:   state_in = pgmb_pkg::ST_PREP;
                  pgmb_pkg::CMD_READ:  state_in = pgmb_pkg::ST_RANGE;
                  pgmb_pkg::CMD_CLEAR: state_in = pgmb_pkg::ST_CLEAR;
                  default:             state_in = pgmb_pkg::ST_RESP;
               endcase
            end
         end
         pgmb_pkg::ST_PREP:   state_in = pgmb_pkg::ST_XSTART;
         pgmb_pkg::ST_XSTART: state_in = coord_neg ? pgmb_pkg::ST_RESP : pgmb_pkg::ST_DIVX;
         pgmb_pkg::ST_DIVX:   if (div_done) state_in = pgmb_pkg::ST_DIVY;
         pgmb_pkg::ST_DIVY:   if (div_done) state_in = pgmb_pkg::ST_RANGE;
         pgmb_pkg::ST_RANGE:  state_in = out_rng ? pgmb_pkg::ST_RESP : pgmb_pkg::ST_FETCH;
         pgmb_pkg::ST_FETCH:  state_in = pgmb_pkg::ST_APPLY;
         pgmb_pkg::ST_APPLY: begin
            if (cmd_ff == pgmb_pkg::CMD_READ && rd_cnt != '0) begin
               state_in = pgmb_pkg::ST_DIVM;
            end else begin
               state_in = pgmb_pkg::ST_RESP;
            end
         end
         pgmb_pkg::ST_DIVM:   if (div_done) state_in = pgmb_pkg::ST_RESP;
         pgmb_pkg::ST_RESP:   if (!rsp_stall) state_in = pgmb_pkg::ST_IDLE;
         default:             state_in = pgmb_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall    = 1'b1;
      rsp_valid    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = cell_addr;
      ram_wdata    = '0;
      ram_raddr    = cell_addr;
      div_start    = 1'b0;
      div_dividend = DIV_W'(dy_ff[31:0]);
      div_divisor  = (cell_size_ff == '0) ? 24'd1 : cell_size_ff;
      unique case (state_ff)
         pgmb_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_ff;
         end
         pgmb_pkg::ST_IDLE:   req_stall = 1'b0;
         pgmb_pkg::ST_XSTART: begin
            div_start    = !coord_neg;
            div_dividend = DIV_W'(dx_ff[31:0]);
         end
         pgmb_pkg::ST_DIVX:   div_start = div_done;
         pgmb_pkg::ST_APPLY: begin
            if (cmd_ff == pgmb_pkg::CMD_READ) begin
               div_start    = rd_cnt != '0;
               div_dividend = DIV_W'(sum_mag);
               div_divisor  = 24'(rd_cnt);
            end else if (write_mode_ff) begin
               ram_we    = 1'b1;
               ram_wdata = {z_ext, COUNT_BITS'(1)};
            end else if (rd_cnt != {COUNT_BITS{1'b1}}) begin
               ram_we    = 1'b1;
               ram_wdata = {sum_plus, cnt_plus};
            end
         end
         pgmb_pkg::ST_RESP:   rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pgmb_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
         clr_rsp_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == pgmb_pkg::ST_CLEAR) begin
            clr_addr_ff <= clr_last ? '0 : clr_addr_ff + ADDR_W'(1);
         end
         if (req_take) begin
            clr_rsp_ff <= req_command == pgmb_pkg::CMD_CLEAR;
         end
      end
   end

   // item datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         pgmb_pkg::ST_IDLE: begin
            if (req_take) begin
               cmd_ff     <= req_command;
               px_ff      <= req_point_x;
               py_ff      <= req_point_y;
               pz_ff      <= req_point_z;
               row_q_ff   <= DIV_W'(req_read_row);
               col_q_ff   <= DIV_W'(req_read_col);
               status_ff  <= pgmb_pkg::STAT_DONE;
               row_out_ff <= '0;
               col_out_ff <= '0;
               mean_ff    <= '0;
               hit_ff     <= '0;
            end
         end
         pgmb_pkg::ST_PREP: begin
            dx_ff <= {px_ff[31], px_ff} - {origin_x_ff[31], origin_x_ff};
            dy_ff <= {py_ff[31], py_ff} - {origin_y_ff[31], origin_y_ff};
         end
         pgmb_pkg::ST_XSTART: begin
            if (coord_neg) status_ff <= pgmb_pkg::STAT_OUTSIDE;
         end
         pgmb_pkg::ST_DIVX: begin
            if (div_done) col_q_ff <= div_quot;
         end
         pgmb_pkg::ST_DIVY: begin
            if (div_done) row_q_ff <= div_quot;
         end
         pgmb_pkg::ST_RANGE: begin
            if (out_rng) begin
               status_ff <= pgmb_pkg::STAT_OUTSIDE;
               if (cmd_ff == pgmb_pkg::CMD_READ) begin
                  row_out_ff <= row_q_ff[5:0];
                  col_out_ff <= col_q_ff[5:0];
               end
            end else begin
               row_out_ff <= row_q_ff[5:0];
               col_out_ff <= col_q_ff[5:0];
            end
         end
         pgmb_pkg::ST_APPLY: begin
            neg_ff <= rd_sum[SUM_W-1];
            if (cmd_ff == pgmb_pkg::CMD_READ) begin
               hit_ff <= sat_hit(rd_cnt);
            end else if (write_mode_ff) begin
               hit_ff <= 16'd1;
            end else if (rd_cnt == {COUNT_BITS{1'b1}}) begin
               status_ff <= pgmb_pkg::STAT_SAT;
               hit_ff    <= sat_hit(rd_cnt);
            end else begin
               hit_ff <= sat_hit(cnt_plus);
            end
         end
         pgmb_pkg::ST_DIVM: begin
            if (div_done) mean_ff <= neg_ff ? (~quot24 + 24'd1) : quot24;
         end
         default: ;
      endcase
   end

   assign rsp_status      = status_ff;
   assign rsp_cell_row    = row_out_ff;
   assign rsp_cell_col    = col_out_ff;
   assign rsp_mean_height = mean_ff;
   assign rsp_hit_count   = hit_ff;

endmodule

`default_nettype wire

>>> hdl/pgmb_chk.sv
// pgmb_chk: port-level checker for the height-grid binner, bound to the top level.
// Uses assert_macros.svh and pgmb_pkg.
`default_nettype none
`include "assert_macros.svh"

module pgmb_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic [23:0] rsp_mean_height,
   input wire logic [15:0] rsp_hit_count
);

   `PGMB_ASSERT(a_status_code, clock, reset, !rsp_valid || rsp_status == pgmb_pkg::STAT_DONE || rsp_status == pgmb_pkg::STAT_OUTSIDE || rsp_status == pgmb_pkg::STAT_SAT)
   `PGMB_ASSERT(a_busy_on_rsp, clock, reset, !rsp_valid || req_stall)
   `PGMB_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)
   `PGMB_ASSERT(a_sat_fields, clock, reset, !(rsp_valid && rsp_status == pgmb_pkg::STAT_SAT) || (rsp_hit_count != 16'd0 && rsp_mean_height == 24'd0))
   `PGMB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_hit_count))

endmodule

bind point_grid_mean_binning_top pgmb_chk u_pgmb_chk (.*);

`default_nettype wire
